// ----- rtl/ulfr_pkg.sv -----
// Shared types and constants for the idle-line UART receive buffer.
package ulfr_pkg;

  localparam int unsigned DATA_W           = 8;
  localparam int unsigned TICKS_W          = 16;
  localparam int unsigned IDX_W            = 6;
  localparam int unsigned FILL_W           = 7;
  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  localparam logic [TICKS_W-1:0] IDLE_TICKS_RST = 16'd256;
  localparam logic [DATA_W-1:0]  TERMINATOR     = 8'h00;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // Flags of one result, plus whether the read hits a filled entry.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic              err;
    logic [FILL_W-1:0] fill;
    logic              hit;
  } status_t;

endpackage

// ----- rtl/ulfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ulfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ulfr_ctrl.sv -----
// Receive state update: fill position, idle timer, flags and buffer accesses.
module ulfr_ctrl #(
  parameter int unsigned BUFFER_DEPTH = ulfr_pkg::BUFFER_DEPTH_DEF,
  localparam int unsigned AW  = $clog2(BUFFER_DEPTH),
  localparam int unsigned WPW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       kind_i,
  input  logic [ulfr_pkg::DATA_W-1:0]      rx_byte_i,
  input  logic                             frame_error_i,
  input  logic                             overrun_i,
  input  logic [ulfr_pkg::IDX_W-1:0]       read_index_i,
  input  logic                             idle_ticks_we_i,
  input  logic [ulfr_pkg::TICKS_W-1:0]     idle_ticks_i,
  input  logic                             s1_adv_i,
  output logic                             s1_valid_o,
  output ulfr_pkg::status_t                s1_status_o,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output logic [ulfr_pkg::DATA_W-1:0]      mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AW-1:0]                    mem_raddr_o
);

  localparam int unsigned CMPW = (WPW > ulfr_pkg::IDX_W) ? WPW : ulfr_pkg::IDX_W;
  localparam int unsigned LW   = (WPW > ulfr_pkg::FILL_W) ? WPW : ulfr_pkg::FILL_W;

  ulfr_pkg::kind_e kind;
  logic                         accept;
  logic                         room;
  logic                         bad;
  logic [CMPW-1:0]              ridx_ext;
  logic [LW-1:0]                fill_ext;
  logic [ulfr_pkg::TICKS_W-1:0] cnt_inc;

  logic [ulfr_pkg::TICKS_W-1:0] ticks_q;
  logic [WPW-1:0]               wp_q, wp_d;
  logic [ulfr_pkg::TICKS_W-1:0] cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic                         done_q, done_d;
  logic                         ovf_q, ovf_d;
  logic                         err_q, err_d;
  logic                         s1_valid_q;
  ulfr_pkg::status_t            s1_status_q, s1_status_d;

  assign kind       = ulfr_pkg::kind_e'(kind_i);
  assign in_stall_o = s1_valid_q & ~s1_adv_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign room       = wp_q < WPW'(BUFFER_DEPTH);
  assign ridx_ext   = CMPW'(read_index_i);
  assign cnt_inc    = cnt_q + ulfr_pkg::TICKS_W'(1);

  always_comb begin
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    done_d      = done_q;
    ovf_d       = ovf_q;
    err_d       = err_q;
    bad         = 1'b0;
    mem_we_o    = 1'b0;
    mem_wdata_o = rx_byte_i;
    if (accept) begin
      unique case (kind)
        ulfr_pkg::KIND_BYTE: begin
          bad = ovf_q | frame_error_i | overrun_i;
          // first byte after a flush arms the timer, good or not
          if (wp_q == '0) begin
            run_d = 1'b1;
            cnt_d = '0;
          end
          if (!bad) begin
            if (room) begin
              cnt_d    = '0;
              mem_we_o = 1'b1;
              wp_d     = wp_q + WPW'(1);
            end else begin
              // drop on full buffer
              ovf_d = 1'b1;
              bad   = 1'b1;
            end
          end
          err_d = bad;
        end
        ulfr_pkg::KIND_TICK: begin
          if (run_q) begin
            if (cnt_inc >= ticks_q) begin
              run_d  = 1'b0;
              cnt_d  = '0;
              done_d = 1'b1;
              if (room) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = ulfr_pkg::TERMINATOR;
                wp_d        = wp_q + WPW'(1);
              end
            end else begin
              cnt_d = cnt_inc;
            end
          end
        end
        ulfr_pkg::KIND_FLUSH: begin
          wp_d   = '0;
          cnt_d  = '0;
          run_d  = 1'b0;
          done_d = 1'b0;
          ovf_d  = 1'b0;
          err_d  = 1'b0;
        end
        ulfr_pkg::KIND_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_waddr_o = wp_q[AW-1:0];
  assign mem_re_o    = accept && (kind == ulfr_pkg::KIND_READ);
  assign mem_raddr_o = ridx_ext[AW-1:0];
  assign fill_ext    = LW'(wp_d);

  always_comb begin
    s1_status_d.done = done_d;
    s1_status_d.ovf  = ovf_d;
    s1_status_d.err  = err_d;
    s1_status_d.fill = fill_ext[ulfr_pkg::FILL_W-1:0];
    // entries below the fill position were all written since the last flush
    s1_status_d.hit  = (kind == ulfr_pkg::KIND_READ) && (ridx_ext < CMPW'(wp_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= ulfr_pkg::IDLE_TICKS_RST;
      wp_q       <= '0;
      cnt_q      <= '0;
      run_q      <= 1'b0;
      done_q     <= 1'b0;
      ovf_q      <= 1'b0;
      err_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (idle_ticks_we_i) begin
        ticks_q <= idle_ticks_i;
      end
      wp_q   <= wp_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
      ovf_q  <= ovf_d;
      err_q  <= err_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= s1_status_d;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_status_o = s1_status_q;

endmodule

// ----- rtl/ulfr_out.sv -----
// Output register: merges status with the buffer read data and holds it under stall.
module ulfr_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  ulfr_pkg::status_t           s1_status_i,
  input  logic [ulfr_pkg::DATA_W-1:0] mem_rdata_i,
  output logic                        s1_adv_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        message_done_o,
  output logic                        overflow_o,
  output logic                        error_o,
  output logic [ulfr_pkg::FILL_W-1:0] fill_level_o,
  output logic [ulfr_pkg::DATA_W-1:0] read_data_o
);

  logic                        out_valid_q;
  logic                        done_q, ovf_q, err_q;
  logic [ulfr_pkg::FILL_W-1:0] fill_q;
  logic [ulfr_pkg::DATA_W-1:0] data_q;

  assign s1_adv_o = s1_valid_i & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o) begin
      done_q <= s1_status_i.done;
      ovf_q  <= s1_status_i.ovf;
      err_q  <= s1_status_i.err;
      fill_q <= s1_status_i.fill;
      data_q <= s1_status_i.hit ? mem_rdata_i : ulfr_pkg::TERMINATOR;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_done_o = done_q;
  assign overflow_o     = ovf_q;
  assign error_o        = err_q;
  assign fill_level_o   = fill_q;
  assign read_data_o    = data_q;

endmodule

// ----- rtl/uart_idle_line_frame_receiver_unit.sv -----
// Top level of the UART receive buffer with idle-line message detection.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o     kind, rx_byte, frame_error, overrun,
//                                                    read_index
//   output    out        out_valid_o / out_stall_i   message_done, overflow, error,
//                                                    fill_level, read_data
//   config    in         idle_ticks_we_i             idle_ticks_i
//
// One item per cycle while out_stall_i is low; a result passes the registered read
// of the byte store and then the output register.
// Reset clears the fill position, timer, flags and sets idle_ticks to 256; the byte
// store is not cleared, reads are masked by the fill position instead.
// An output stall holds the result; while the stage behind the output register is
// occupied and cannot advance, the input stalls in the same cycle.
module uart_idle_line_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = ulfr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [ulfr_pkg::DATA_W-1:0]  rx_byte_i,
  input  logic                         frame_error_i,
  input  logic                         overrun_i,
  input  logic [ulfr_pkg::IDX_W-1:0]   read_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         message_done_o,
  output logic                         overflow_o,
  output logic                         error_o,
  output logic [ulfr_pkg::FILL_W-1:0]  fill_level_o,
  output logic [ulfr_pkg::DATA_W-1:0]  read_data_o,
  input  logic                         idle_ticks_we_i,
  input  logic [ulfr_pkg::TICKS_W-1:0] idle_ticks_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic                        s1_adv;
  logic                        s1_valid;
  ulfr_pkg::status_t           s1_status;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ulfr_pkg::DATA_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [ulfr_pkg::DATA_W-1:0] mem_rdata;

  ulfr_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .rx_byte_i       (rx_byte_i),
    .frame_error_i   (frame_error_i),
    .overrun_i       (overrun_i),
    .read_index_i    (read_index_i),
    .idle_ticks_we_i (idle_ticks_we_i),
    .idle_ticks_i    (idle_ticks_i),
    .s1_adv_i        (s1_adv),
    .s1_valid_o      (s1_valid),
    .s1_status_o     (s1_status),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr)
  );

  ulfr_ram #(
    .WIDTH(ulfr_pkg::DATA_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ulfr_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid),
    .s1_status_i    (s1_status),
    .mem_rdata_i    (mem_rdata),
    .s1_adv_o       (s1_adv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .message_done_o (message_done_o),
    .overflow_o     (overflow_o),
    .error_o        (error_o),
    .fill_level_o   (fill_level_o),
    .read_data_o    (read_data_o)
  );

endmodule

// ----- rtl/ulfr_checker.sv -----
// Port-level checks for the receive buffer, bound to the top level.
module ulfr_checker #(
  parameter int unsigned BUFFER_DEPTH = ulfr_pkg::BUFFER_DEPTH_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         overflow_o,
  input logic                         error_o,
  input logic [ulfr_pkg::FILL_W-1:0]  fill_level_o,
  input logic [ulfr_pkg::DATA_W-1:0]  read_data_o
);

  localparam bit SMALL = BUFFER_DEPTH < 128;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fill_level_o)
      && $stable(read_data_o) && $stable(error_o))
    else $error("stalled result changed");

  // every byte after an overflow is in error until a flush clears both
  a_ovf_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> error_o)
    else $error("overflow shown without error");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL |-> fill_level_o <= ulfr_pkg::FILL_W'(BUFFER_DEPTH))
    else $error("fill level beyond buffer depth");

  // nonzero data can only come from a filled entry
  a_read_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL && (read_data_o != '0) |-> fill_level_o != '0)
    else $error("read data from an empty buffer");

endmodule

bind uart_idle_line_frame_receiver_unit ulfr_checker #(
  .BUFFER_DEPTH(BUFFER_DEPTH)
) u_ulfr_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the idle-line UART receive buffer.
module tb;

  localparam int unsigned DEPTH           = ulfr_pkg::BUFFER_DEPTH_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned SHOWN_FAILURES  = 10;

  typedef struct packed {
    ulfr_pkg::kind_e                kind;
    logic [ulfr_pkg::DATA_W-1:0]    data;
    logic                           fe;
    logic                           ov;
    logic [ulfr_pkg::IDX_W-1:0]     idx;
  } rx_item_t;

  typedef struct packed {
    logic                           done;
    logic                           ovf;
    logic                           err;
    logic [ulfr_pkg::FILL_W-1:0]    fill;
    logic [ulfr_pkg::DATA_W-1:0]    rdata;
  } rx_status_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     kind_i          = ulfr_pkg::KIND_BYTE;
  logic [ulfr_pkg::DATA_W-1:0]    rx_byte_i       = '0;
  logic                           frame_error_i   = 1'b0;
  logic                           overrun_i       = 1'b0;
  logic [ulfr_pkg::IDX_W-1:0]     read_index_i    = '0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic                           message_done_o;
  logic                           overflow_o;
  logic                           error_o;
  logic [ulfr_pkg::FILL_W-1:0]    fill_level_o;
  logic [ulfr_pkg::DATA_W-1:0]    read_data_o;
  logic                           idle_ticks_we_i = 1'b0;
  logic [ulfr_pkg::TICKS_W-1:0]   idle_ticks_i    = ulfr_pkg::IDLE_TICKS_RST;

  uart_idle_line_frame_receiver_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .rx_byte_i       (rx_byte_i),
    .frame_error_i   (frame_error_i),
    .overrun_i       (overrun_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .message_done_o  (message_done_o),
    .overflow_o      (overflow_o),
    .error_o         (error_o),
    .fill_level_o    (fill_level_o),
    .read_data_o     (read_data_o),
    .idle_ticks_we_i (idle_ticks_we_i),
    .idle_ticks_i    (idle_ticks_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver state as the buffer should hold it.
  logic [ulfr_pkg::DATA_W-1:0]  rx_store [DEPTH];
  logic [ulfr_pkg::FILL_W-1:0]  fill_q       = '0;
  logic [ulfr_pkg::TICKS_W-1:0] idle_cnt_q   = '0;
  logic                         timer_on_q   = 1'b0;
  logic                         done_q       = 1'b0;
  logic                         ovf_q        = 1'b0;
  logic                         err_q        = 1'b0;
  logic [ulfr_pkg::TICKS_W-1:0] idle_limit_q = ulfr_pkg::IDLE_TICKS_RST;

  rx_item_t   rx_items [$];
  rx_status_t status_due [$];
  rx_item_t   on_deck;

  int unsigned queued, accepted, checked, failures;
  int unsigned timeouts_seen, drops_seen;
  int unsigned send_gap, stall_left;
  bit          idling = 1'b1;
  bit          in_taken = 1'b0;

  function automatic rx_status_t next_status(input rx_item_t it);
    rx_status_t r;
    logic       bad;
    r = '0;
    case (it.kind)
      ulfr_pkg::KIND_BYTE: begin
        bad = ovf_q || it.fe || it.ov;
        // the first byte after a flush arms the timer, good or not
        if (fill_q == '0) begin
          timer_on_q = 1'b1;
          idle_cnt_q = '0;
        end
        if (!bad) begin
          if (fill_q < ulfr_pkg::FILL_W'(DEPTH)) begin
            idle_cnt_q = '0;
            rx_store[fill_q[ulfr_pkg::IDX_W-1:0]] = it.data;
            fill_q = fill_q + ulfr_pkg::FILL_W'(1);
          end else begin
            ovf_q = 1'b1;
            bad = 1'b1;
            drops_seen++;
          end
        end
        err_q = bad;
      end
      ulfr_pkg::KIND_TICK: begin
        if (timer_on_q) begin
          idle_cnt_q = idle_cnt_q + ulfr_pkg::TICKS_W'(1);
          if (idle_cnt_q >= idle_limit_q) begin
            timer_on_q = 1'b0;
            idle_cnt_q = '0;
            done_q = 1'b1;
            timeouts_seen++;
            // no terminator when the buffer is already full
            if (fill_q < ulfr_pkg::FILL_W'(DEPTH)) begin
              rx_store[fill_q[ulfr_pkg::IDX_W-1:0]] = ulfr_pkg::TERMINATOR;
              fill_q = fill_q + ulfr_pkg::FILL_W'(1);
            end
          end
        end
      end
      ulfr_pkg::KIND_FLUSH: begin
        fill_q = '0;
        idle_cnt_q = '0;
        timer_on_q = 1'b0;
        done_q = 1'b0;
        ovf_q = 1'b0;
        err_q = 1'b0;
      end
      default: begin
        if ({1'b0, it.idx} < fill_q) r.rdata = rx_store[it.idx];
      end
    endcase
    r.done = done_q;
    r.ovf = ovf_q;
    r.err = err_q;
    r.fill = fill_q;
    return r;
  endfunction

  task automatic note_failure(input string what, input rx_status_t want,
                              input rx_status_t got);
    failures++;
    if (failures <= SHOWN_FAILURES) begin
      $display("%0t %s: expected done=%0b ovf=%0b err=%0b fill=%0d data=%02h,",
               $time, what, want.done, want.ovf, want.err, want.fill, want.rdata);
      $display("  got done=%0b ovf=%0b err=%0b fill=%0d data=%02h",
               got.done, got.ovf, got.err, got.fill, got.rdata);
    end
  endtask

  task automatic send(input ulfr_pkg::kind_e k, input int unsigned d, input int unsigned fe,
                      input int unsigned ov, input int unsigned ix);
    rx_items.push_back('{kind: k, data: ulfr_pkg::DATA_W'(d), fe: 1'(fe), ov: 1'(ov),
                         idx: ulfr_pkg::IDX_W'(ix)});
    queued++;
  endtask

  // Driver: move to the next item once the current transfer is done.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 8);
        in_valid_i <= 1'b0;
      end else if (rx_items.size() != 0) begin
        on_deck = rx_items.pop_front();
        in_valid_i    <= 1'b1;
        kind_i        <= on_deck.kind;
        rx_byte_i     <= on_deck.data;
        frame_error_i <= on_deck.fe;
        overrun_i     <= on_deck.ov;
        read_index_i  <= on_deck.idx;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver side stall bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk_i) begin
    rx_item_t   seen;
    rx_status_t want;
    rx_status_t got;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      seen = '{kind: ulfr_pkg::kind_e'(kind_i), data: rx_byte_i, fe: frame_error_i,
               ov: overrun_i, idx: read_index_i};
      status_due.push_back(next_status(seen));
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {message_done_o, overflow_o, error_o, fill_level_o, read_data_o};
      if (status_due.size() == 0) begin
        note_failure("result with nothing pending", '0, got);
      end else begin
        want = status_due.pop_front();
        checked++;
        if (got.done !== want.done || got.ovf !== want.ovf || got.err !== want.err ||
            got.fill !== want.fill || got.rdata !== want.rdata)
          note_failure("status mismatch", want, got);
      end
    end
  end

  // Hold until every queued item has been transferred and answered.
  task automatic settle();
    do @(negedge clk_i);
    while (rx_items.size() != 0 || in_valid_i || status_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_idle_ticks(input logic [ulfr_pkg::TICKS_W-1:0] v);
    settle();
    idle_ticks_we_i <= 1'b1;
    idle_ticks_i    <= v;
    @(negedge clk_i);
    idle_ticks_we_i <= 1'b0;
    idle_limit_q = v;
  endtask

  // One message: optional flush, bytes with short tick gaps, idle ticks, reads, optional random items.
  task automatic queue_message(input int unsigned limit);
    int unsigned n;
    int unsigned gap_max;
    bit          long_msg;
    int unsigned fe;
    long_msg = ($urandom_range(0, 4) == 0);
    n = long_msg ? $urandom_range(66, 74) : $urandom_range(1, 10);
    gap_max = (limit > 3) ? 2 : limit - 1;
    if ($urandom_range(0, 3) != 0)
      send(ulfr_pkg::KIND_FLUSH, $urandom_range(0, 255), $urandom_range(0, 1),
           $urandom_range(0, 1), $urandom_range(0, 63));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        fe = $urandom_range(0, 1);
        send(ulfr_pkg::KIND_BYTE, $urandom_range(0, 255), fe,
             (fe != 0) ? $urandom_range(0, 1) : 1, $urandom_range(0, 63));
      end else begin
        send(ulfr_pkg::KIND_BYTE, $urandom_range(0, 255), 0, 0, $urandom_range(0, 63));
      end
      repeat ($urandom_range(0, gap_max))
        send(ulfr_pkg::KIND_TICK, $urandom_range(0, 255), $urandom_range(0, 1),
             $urandom_range(0, 1), $urandom_range(0, 63));
    end
    repeat ((limit <= 20) ? limit + $urandom_range(0, 2) : $urandom_range(1, 4))
      send(ulfr_pkg::KIND_TICK, $urandom_range(0, 255), $urandom_range(0, 1),
           $urandom_range(0, 1), $urandom_range(0, 63));
    repeat ($urandom_range(2, 5))
      send(ulfr_pkg::KIND_READ, $urandom_range(0, 255), $urandom_range(0, 1),
           $urandom_range(0, 1), long_msg ? $urandom_range(0, 63) : $urandom_range(0, n + 2));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send(ulfr_pkg::kind_e'(2'($urandom_range(0, 3))), $urandom_range(0, 255),
             $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 63));
  endtask

  initial begin
    logic [ulfr_pkg::TICKS_W-1:0] limits [8];
    int unsigned                  start;
    limits = '{16'd2, 16'd65535, 16'd5, 16'd1, 16'd16, 16'd3, 16'd8, 16'd256};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: empty reads, stopped timer, errored first byte
    send(ulfr_pkg::KIND_READ, 'h00, 0, 0, 0);
    send(ulfr_pkg::KIND_TICK, 'hFF, 1, 1, 63);
    send(ulfr_pkg::KIND_BYTE, 'h00, 1, 0, 0);
    send(ulfr_pkg::KIND_BYTE, 'hFF, 0, 0, 63);
    send(ulfr_pkg::KIND_BYTE, 'hA5, 0, 1, 0);
    send(ulfr_pkg::KIND_BYTE, 'h5A, 1, 1, 0);
    send(ulfr_pkg::KIND_READ, 'h00, 0, 0, 0);
    send(ulfr_pkg::KIND_READ, 'hFF, 1, 1, 63);
    send(ulfr_pkg::KIND_FLUSH, 'h00, 0, 0, 0);

    // one-tick timeout, then bytes past the terminator with the timer stopped
    set_idle_ticks(16'd1);
    send(ulfr_pkg::KIND_BYTE, 'h81, 0, 0, 0);
    send(ulfr_pkg::KIND_TICK, 'h00, 0, 0, 0);
    send(ulfr_pkg::KIND_BYTE, 'h7E, 0, 0, 0);
    send(ulfr_pkg::KIND_TICK, 'h00, 0, 0, 0);
    send(ulfr_pkg::KIND_READ, 'h00, 0, 0, 1);
    send(ulfr_pkg::KIND_READ, 'h00, 0, 0, 2);
    send(ulfr_pkg::KIND_FLUSH, 'h00, 0, 0, 0);

    // zero limit completes on the first tick
    set_idle_ticks(16'd0);
    send(ulfr_pkg::KIND_BYTE, 'h3C, 0, 0, 0);
    send(ulfr_pkg::KIND_TICK, 'h00, 0, 0, 0);

    // lower the limit below a running count
    set_idle_ticks(16'd100);
    send(ulfr_pkg::KIND_FLUSH, 'h00, 0, 0, 0);
    send(ulfr_pkg::KIND_BYTE, 'hC3, 0, 0, 0);
    repeat (4) send(ulfr_pkg::KIND_TICK, 'h00, 0, 0, 0);
    set_idle_ticks(16'd2);
    send(ulfr_pkg::KIND_TICK, 'h00, 0, 0, 0);

    foreach (limits[p]) begin
      idling = (p != 7);
      set_idle_ticks(limits[p]);
      start = queued;
      while (queued - start < ITEMS_PER_PHASE) queue_message(32'(limits[p]));
    end

    settle();
    repeat (8) @(negedge clk_i);
    $display("covered %0d transfers over %0d idle-tick settings, %0d results checked",
             accepted, 12, checked);
    $display("saw %0d idle timeouts and %0d bytes dropped on a full buffer",
             timeouts_seen, drops_seen);
    if (failures == 0 && status_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
